>>> src/plr_pkg.sv
// Shared types, constants and helper functions of the pad link responder.
// No dependencies; imported by every module of the block.
package plr_pkg;

    localparam logic [7:0] RX_MASK      = 8'h52;
    localparam logic [7:0] STOP_PATTERN = 8'h52;
    localparam logic [7:0] RX_PAIR_ONE  = 8'h40;
    localparam logic [7:0] RX_PAIR_TWO  = 8'h02;
    localparam logic [7:0] RX_PAIR_THREE = 8'h42;

    localparam logic [7:0] CMD_POLL   = 8'h00;
    localparam logic [7:0] CMD_STATUS = 8'h40;
    localparam logic [7:0] CMD_ORIGIN = 8'h41;

    localparam logic [3:0] CMD_PAIRS = 4'd4;
    localparam logic [3:0] ARG_PAIRS = 4'd8;

    localparam logic [5:0] TX_CODE_ZERO  = 6'h04;
    localparam logic [5:0] TX_CODE_ONE   = 6'h34;
    localparam logic [5:0] TX_CODE_TWO   = 6'h07;
    localparam logic [5:0] TX_CODE_THREE = 6'h37;
    localparam logic [5:0] TX_CODE_STOP  = 6'h3F;

    // Answer bytes, most significant byte first, left-aligned in the shifter.
    localparam int unsigned ANS_BITS = 80;
    localparam logic [23:0] POLL_BYTES   = 24'h09_00_03;
    localparam logic [79:0] ORIGIN_BYTES = 80'h00_80_80_80_80_80_00_00_00_00;

    // Pair codes per answer: four per byte.
    localparam logic [5:0] POLL_CODES   = 6'd12;
    localparam logic [5:0] ORIGIN_CODES = 6'd40;
    localparam logic [5:0] STATUS_CODES = 6'd32;

    typedef enum logic [0:0] {
        PH_CMD,
        PH_ARG
    } rx_phase_t;

    typedef enum logic [1:0] {
        ANS_POLL,
        ANS_ORIGIN,
        ANS_STATUS
    } ans_kind_t;

    typedef struct packed {
        logic      valid;
        ans_kind_t kind;
        logic      rumble;
    } ans_req_t;

    function automatic logic [1:0] decode_pair(input logic [7:0] masked);
        logic [1:0] pair;
        case (masked)
            RX_PAIR_ONE:   pair = 2'd1;
            RX_PAIR_TWO:   pair = 2'd2;
            RX_PAIR_THREE: pair = 2'd3;
            default:       pair = 2'd0;
        endcase
        return pair;
    endfunction

    function automatic logic [5:0] pair_code(input logic [1:0] pair);
        logic [5:0] code;
        case (pair)
            2'd0:    code = TX_CODE_ZERO;
            2'd1:    code = TX_CODE_ONE;
            2'd2:    code = TX_CODE_TWO;
            default: code = TX_CODE_THREE;
        endcase
        return code;
    endfunction

endpackage

>>> src/plr_cmd_fsm.sv
// Receive state machine: decodes bit pairs, assembles commands, tracks rumble.
// Depends on plr_pkg.
module plr_cmd_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output plr_pkg::ans_req_t ans_req
);
    import plr_pkg::*;

    rx_phase_t  phase_reg, phase_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] cmd_reg, cmd_next;
    logic       rumble_reg, rumble_next;

    logic [7:0] masked;
    logic [1:0] pair;
    logic [3:0] count_inc;
    logic [7:0] cmd_shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_CMD;
            count_reg  <= '0;
            cmd_reg    <= '0;
            rumble_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            cmd_reg    <= cmd_next;
            rumble_reg <= rumble_next;
        end
    end

    always_comb begin
        masked      = rx_byte & RX_MASK;
        pair        = decode_pair(masked);
        count_inc   = count_reg + 4'd1;
        cmd_shifted = {cmd_reg[5:0], pair};

        phase_next     = phase_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        rumble_next    = rumble_reg;
        ans_req.valid  = 1'b0;
        ans_req.kind   = ANS_POLL;
        ans_req.rumble = rumble_reg;

        if (accept) begin
            if (masked == STOP_PATTERN) begin
                // Stop pattern: drop back to idle, keep rumble.
                phase_next = PH_CMD;
                count_next = '0;
                cmd_next   = '0;
            end else begin
                case (phase_reg)
                    PH_ARG: begin
                        count_next = count_inc;
                        if (count_inc >= ARG_PAIRS) begin
                            rumble_next    = pair[0];
                            ans_req.valid  = 1'b1;
                            ans_req.kind   = ANS_STATUS;
                            ans_req.rumble = pair[0];
                            phase_next     = PH_CMD;
                            count_next     = '0;
                            cmd_next       = '0;
                        end
                    end
                    default: begin
                        cmd_next   = cmd_shifted;
                        count_next = count_inc;
                        if (count_inc >= CMD_PAIRS) begin
                            phase_next = PH_CMD;
                            count_next = '0;
                            cmd_next   = '0;
                            case (cmd_shifted)
                                CMD_STATUS: begin
                                    phase_next = PH_ARG;
                                    cmd_next   = cmd_shifted;
                                end
                                CMD_POLL: begin
                                    ans_req.valid = 1'b1;
                                    ans_req.kind  = ANS_POLL;
                                end
                                CMD_ORIGIN: begin
                                    ans_req.valid = 1'b1;
                                    ans_req.kind  = ANS_ORIGIN;
                                end
                                default: begin
                                    ans_req.valid = 1'b0;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

endmodule

>>> src/plr_tx_shifter.sv
// Answer shifter: loads answer bytes, emits one 6-bit code per 2-bit pair, one per word, then stop.
// Depends on plr_pkg.
module plr_tx_shifter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  plr_pkg::ans_req_t ans_req,
    input  logic [7:0]        pin_levels,
    input  logic [3:0]        dpad_bits,
    input  logic [7:0]        main_x,
    input  logic [7:0]        main_y,
    input  logic [7:0]        aux_x,
    input  logic [7:0]        aux_y,
    input  logic [7:0]        trigger_left,
    input  logic [7:0]        trigger_right,
    output logic              idle,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [5:0]        m_tx_code,
    output logic              m_rumble_on,
    output logic              m_last_code
);
    import plr_pkg::*;

    logic [ANS_BITS-1:0] shift_reg, shift_next;
    logic [5:0]          left_reg, left_next;
    logic                stop_reg, stop_next;
    logic                rumble_reg, rumble_next;
    logic                valid_reg, valid_next;
    logic [5:0]          code_reg, code_next;
    logic                last_reg, last_next;
    logic                orumble_reg, orumble_next;

    logic [7:0]          pins;
    logic [ANS_BITS-1:0] load_vec;
    logic [5:0]          load_len;
    logic                advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            stop_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            left_reg  <= left_next;
            stop_reg  <= stop_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg   <= shift_next;
        rumble_reg  <= rumble_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
        orumble_reg <= orumble_next;
    end

    always_comb begin
        pins = ~pin_levels;
        case (ans_req.kind)
            ANS_POLL: begin
                load_vec = {POLL_BYTES, {(ANS_BITS - 24){1'b0}}};
                load_len = POLL_CODES;
            end
            ANS_ORIGIN: begin
                load_vec = ORIGIN_BYTES;
                load_len = ORIGIN_CODES;
            end
            ANS_STATUS: begin
                load_vec = {3'b000, pins[4:0], 1'b1, pins[7:5], dpad_bits,
                            main_x, main_y, aux_x, aux_y, trigger_left, trigger_right,
                            16'h0000};
                load_len = STATUS_CODES;
            end
            default: begin
                load_vec = '0;
                load_len = '0;
            end
        endcase
    end

    always_comb begin
        advance      = !valid_reg || m_ready;
        shift_next   = shift_reg;
        left_next    = left_reg;
        stop_next    = stop_reg;
        rumble_next  = rumble_reg;
        valid_next   = valid_reg;
        code_next    = code_reg;
        last_next    = last_reg;
        orumble_next = orumble_reg;

        if (advance) begin
            if (left_reg != '0) begin
                code_next    = pair_code(shift_reg[ANS_BITS-1 -: 2]);
                last_next    = 1'b0;
                orumble_next = rumble_reg;
                valid_next   = 1'b1;
                shift_next   = {shift_reg[ANS_BITS-3:0], 2'b00};
                left_next    = left_reg - 6'd1;
            end else if (stop_reg) begin
                code_next    = TX_CODE_STOP;
                last_next    = 1'b1;
                orumble_next = rumble_reg;
                valid_next   = 1'b1;
                stop_next    = 1'b0;
            end else begin
                valid_next = 1'b0;
            end
        end

        // Load only while empty, so it never collides with shifting.
        if (accept && ans_req.valid) begin
            shift_next  = load_vec;
            left_next   = load_len;
            stop_next   = 1'b1;
            rumble_next = ans_req.rumble;
        end
    end

    assign idle        = (left_reg == '0) && !stop_reg;
    assign m_valid     = valid_reg;
    assign m_tx_code   = code_reg;
    assign m_last_code = last_reg;
    assign m_rumble_on = orumble_reg;

endmodule

>>> src/pad_link_responder.sv
// Top level of the pad link responder: receive state machine plus answer shifter.
// Depends on plr_pkg, plr_cmd_fsm and plr_tx_shifter.
//
//  channel | direction | words                      | handshake
//  s_      | in        | one received UART byte     | s_valid / s_ready
//  m_      | out       | one 6-bit UART code        | m_valid / m_ready
//
// A byte that causes no answer is taken and leaves s_ready high.
// A byte that completes a command loads the answer shifter: 4 codes per answer
// byte plus a stop code, one per cycle while the output is not stalled, taken
// two bits at a time from the 80-bit answer shift register.
// s_ready drops while codes remain and rises once the stop code sits in the
// output register; output stalls hold the shifter, and with it the input.
// Reset (aresetn low, synchronous) returns to command idle with the stored rumble flag cleared.
module pad_link_responder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_pin_levels,
    input  logic [3:0] s_dpad_bits,
    input  logic [7:0] s_main_x,
    input  logic [7:0] s_main_y,
    input  logic [7:0] s_aux_x,
    input  logic [7:0] s_aux_y,
    input  logic [7:0] s_trigger_left,
    input  logic [7:0] s_trigger_right,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_tx_code,
    output logic       m_rumble_on,
    output logic       m_last_code
);
    import plr_pkg::*;

    logic     accept;
    logic     tx_idle;
    ans_req_t ans_req;

    // Take a word only while no answer codes are left to shift out.
    assign s_ready = tx_idle;
    assign accept  = s_valid && tx_idle;

    plr_cmd_fsm u_cmd_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .ans_req (ans_req)
    );

    plr_tx_shifter u_tx_shifter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .ans_req       (ans_req),
        .pin_levels    (s_pin_levels),
        .dpad_bits     (s_dpad_bits),
        .main_x        (s_main_x),
        .main_y        (s_main_y),
        .aux_x         (s_aux_x),
        .aux_y         (s_aux_y),
        .trigger_left  (s_trigger_left),
        .trigger_right (s_trigger_right),
        .idle          (tx_idle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_code     (m_tx_code),
        .m_rumble_on   (m_rumble_on),
        .m_last_code   (m_last_code)
    );

endmodule

>>> src/plr_checker.sv
// Port-level checks of the pad link responder, bound to the top level.
// Depends on plr_pkg.
module plr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_tx_code,
    input logic       m_rumble_on,
    input logic       m_last_code
);
    import plr_pkg::*;

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_code) && $stable(m_last_code))
        else $error("stalled output word changed");

    // Only pair codes, or the stop code flagged as last.
    a_code_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_code && m_tx_code == TX_CODE_STOP) ||
                    (!m_last_code && (m_tx_code == TX_CODE_ZERO || m_tx_code == TX_CODE_ONE ||
                                      m_tx_code == TX_CODE_TWO || m_tx_code == TX_CODE_THREE)))
        else $error("illegal output code");

    // An answer runs without gaps up to its stop code.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_code |=> m_valid && m_rumble_on == $past(m_rumble_on))
        else $error("answer interrupted or rumble changed mid-answer");

    // No input is taken while an answer is still being sent.
    a_busy_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_code |-> !s_ready)
        else $error("input accepted during answer");

endmodule

bind pad_link_responder plr_checker u_plr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_tx_code   (m_tx_code),
    .m_rumble_on (m_rumble_on),
    .m_last_code (m_last_code)
);
